[rtl/core/msf_pkg.sv]
package msf_pkg;

  // Default number of notes that carry flags.
  localparam int NOTE_COUNT_DEFAULT = 128;

  // Full MIDI note span and the width of one release bank.
  localparam int NOTE_SPAN  = 128;
  localparam int BANK_WIDTH = 64;
  localparam int BANK_SHIFT = 6;

  // Message kinds taken from the upper nibble of the status byte.
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;

  // Sostenuto pedal controller and its on threshold.
  localparam logic [6:0] PEDAL_CTRL      = 7'd66;
  localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;

  // Status nibble used for generated release results.
  localparam logic [3:0] RELEASE_KIND = 4'h8;

  // Result kinds.
  localparam logic RESULT_FORWARD = 1'b0;
  localparam logic RESULT_RELEASE = 1'b1;

  // One input message.
  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [15:0] sample_offset;
  } msg_item_t;

  // One result item.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_status;
    logic [6:0]  out_first;
    logic [6:0]  out_second;
    logic [15:0] out_offset;
    logic        note_bank;
    logic [63:0] release_mask;
    logic        last_of_run;
  } res_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY_HI,
    ST_RELEASE_HI
  } seq_state_t;

  // Operations of the flag bank unit.
  typedef enum logic [2:0] {
    FOP_NONE,
    FOP_COPY,
    FOP_CLEAR,
    FOP_HOLD_SET,
    FOP_HOLD_CLR
  } flag_op_t;

  // Command from the sequencer to the flag unit.
  typedef struct packed {
    flag_op_t   op;
    logic       bank;
    logic [6:0] note;
  } flag_cmd_t;

  // Status from the flag unit back to the sequencer.
  typedef struct packed {
    logic [63:0] release_mask;
    logic        note_latched;
  } flag_status_t;

endpackage

[rtl/core/msf_stream_if.sv]
interface msf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/msf_flags.sv]
module msf_flags #(
  parameter int NOTE_COUNT = msf_pkg::NOTE_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  msf_pkg::flag_cmd_t    cmd,
  output msf_pkg::flag_status_t status
);
  import msf_pkg::*;

  localparam int IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

  logic [NOTE_COUNT-1:0] key_held;
  logic [NOTE_COUNT-1:0] note_latched;
  logic [NOTE_SPAN-1:0]  held_pad;
  logic [NOTE_SPAN-1:0]  latched_pad;
  logic [BANK_WIDTH-1:0] held_bank;
  logic [BANK_WIDTH-1:0] latched_bank;
  logic [IDX_W-1:0]      idx;

  assign idx = cmd.note[IDX_W-1:0];

  // Notes without flags read as neither held nor latched.
  for (genvar g = 0; g < NOTE_SPAN; g++) begin : g_pad
    if (g < NOTE_COUNT) begin : g_live
      assign held_pad[g]    = key_held[g];
      assign latched_pad[g] = note_latched[g];
    end else begin : g_none
      assign held_pad[g]    = 1'b0;
      assign latched_pad[g] = 1'b0;
    end
  end

  // The shared bank unit: one 64-note group is selected per cycle.
  assign held_bank    = cmd.bank ? held_pad[NOTE_SPAN-1:BANK_WIDTH] : held_pad[BANK_WIDTH-1:0];
  assign latched_bank = cmd.bank ? latched_pad[NOTE_SPAN-1:BANK_WIDTH]
                                 : latched_pad[BANK_WIDTH-1:0];

  assign status.release_mask = latched_bank & ~held_bank;
  assign status.note_latched = note_latched[idx];

  // Flag updates, one bank or one note per command.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_held     <= '0;
      note_latched <= '0;
    end else begin
      case (cmd.op)
        FOP_COPY: begin
          for (int i = 0; i < NOTE_COUNT; i++) begin
            if ((i >> BANK_SHIFT) == int'(cmd.bank)) note_latched[i] <= key_held[i];
          end
        end
        FOP_CLEAR: begin
          for (int i = 0; i < NOTE_COUNT; i++) begin
            if ((i >> BANK_SHIFT) == int'(cmd.bank)) note_latched[i] <= 1'b0;
          end
        end
        FOP_HOLD_SET: key_held[idx] <= 1'b1;
        FOP_HOLD_CLR: key_held[idx] <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/midi_sostenuto_filter.sv]
// Channel  Role    Payload      Handshake
// msg      sink    msg_item_t   valid/ready, taken when both high
// res      source  res_item_t   valid/ready, taken when both high
//
// A message is taken while the sequencer is idle and is decoded and executed from
// the captured copy; a pedal message also passes through an upper-bank state,
// because the flag bank unit handles one 64-note bank per cycle.
// Reset is synchronous and clears the held and latched flags at once.
// A result sits in the output register until taken; the next message is taken
// meanwhile, and execution waits only when it must load a result into a full register.
module midi_sostenuto_filter #(
  parameter int NOTE_COUNT = msf_pkg::NOTE_COUNT_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  msf_stream_if.sink   msg,
  msf_stream_if.source res
);
  import msf_pkg::*;

  seq_state_t   state;
  seq_state_t   state_next;
  msg_item_t    msg_r;
  res_item_t    out_item;
  res_item_t    out_item_next;
  logic         out_valid;
  logic         out_load;
  logic         slot_free;
  flag_cmd_t    cmd;
  flag_status_t fstat;

  logic [3:0] kind;
  logic       in_range;
  logic       is_pedal;
  logic       pedal_on;
  logic       is_on;
  logic       is_off;
  logic       drop;

  msf_flags #(.NOTE_COUNT(NOTE_COUNT)) u_flags (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (fstat)
  );

  // Message decode from the captured transaction.
  assign kind     = msg_r.status_byte[7:4];
  assign in_range = {1'b0, msg_r.first_data} < 8'(NOTE_COUNT);
  assign is_pedal = (kind == KIND_CTRL) && (msg_r.first_data == PEDAL_CTRL);
  assign pedal_on = is_pedal && (msg_r.second_data >= PEDAL_THRESHOLD);
  assign is_on    = (kind == KIND_NOTE_ON) && (msg_r.second_data != 7'd0);
  assign is_off   = ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON)) && !is_on;
  assign drop     = is_off && in_range && fstat.note_latched;

  assign slot_free   = !out_valid || res.ready;
  assign msg.ready   = (state == ST_IDLE);
  assign res.valid   = out_valid;
  assign res.payload = out_item;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Message capture.
  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) msg_r <= msg.payload;
  end

  // Next state, flag commands and result loading.
  always_comb begin
    state_next    = state;
    cmd.op        = FOP_NONE;
    cmd.bank      = 1'b0;
    cmd.note      = msg_r.first_data;
    out_load      = 1'b0;
    out_item_next = '0;
    out_item_next.out_offset = msg_r.sample_offset;

    case (state)
      ST_IDLE: begin
        if (msg.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (pedal_on) begin
          cmd.op     = FOP_COPY;
          state_next = ST_COPY_HI;
        end else if (is_pedal) begin
          if (slot_free) begin
            cmd.op                     = FOP_CLEAR;
            out_load                   = 1'b1;
            out_item_next.result_kind  = RESULT_RELEASE;
            out_item_next.out_status   = {RELEASE_KIND, msg_r.status_byte[3:0]};
            out_item_next.release_mask = fstat.release_mask;
            state_next                 = ST_RELEASE_HI;
          end
        end else if (drop) begin
          cmd.op     = FOP_HOLD_CLR;
          state_next = ST_IDLE;
        end else if (slot_free) begin
          if (in_range && is_on) cmd.op = FOP_HOLD_SET;
          else if (in_range && is_off) cmd.op = FOP_HOLD_CLR;
          out_load                  = 1'b1;
          out_item_next.result_kind = RESULT_FORWARD;
          out_item_next.out_status  = msg_r.status_byte;
          out_item_next.out_first   = msg_r.first_data;
          out_item_next.out_second  = msg_r.second_data;
          out_item_next.last_of_run = 1'b1;
          state_next                = ST_IDLE;
        end
      end
      ST_COPY_HI: begin
        cmd.op     = FOP_COPY;
        cmd.bank   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RELEASE_HI: begin
        cmd.bank = 1'b1;
        if (slot_free) begin
          cmd.op                     = FOP_CLEAR;
          out_load                   = 1'b1;
          out_item_next.result_kind  = RESULT_RELEASE;
          out_item_next.out_status   = {RELEASE_KIND, msg_r.status_byte[3:0]};
          out_item_next.note_bank    = 1'b1;
          out_item_next.release_mask = fstat.release_mask;
          out_item_next.last_of_run  = 1'b1;
          state_next                 = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_item <= out_item_next;
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |-> !out_load)
    else $error("result register overwritten while stalled");

  // Release results close the run exactly on the upper bank.
  a_release_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.result_kind == RESULT_RELEASE)
      |-> (res.payload.last_of_run == res.payload.note_bank))
    else $error("release bank and last flag disagree");

  // Forwarded results are single and carry no mask.
  a_forward_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.result_kind == RESULT_FORWARD)
      |-> (res.payload.last_of_run && res.payload.release_mask == 64'd0
           && !res.payload.note_bank))
    else $error("forwarded result carries release fields");

  // The upper bank of a release always follows the lower one.
  a_release_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELEASE_HI) |-> ($past(state) == ST_EXEC || $past(state) == ST_RELEASE_HI))
    else $error("upper release bank without lower bank");

endmodule
